// ===== src/ale_pkg.sv =====
package ale_pkg;

	// Request kinds
	localparam logic [3:0] REQ_CLEAR   = 4'd0;
	localparam logic [3:0] REQ_INSERT  = 4'd1;
	localparam logic [3:0] REQ_DELETE  = 4'd2;
	localparam logic [3:0] REQ_LOCATE  = 4'd3;
	localparam logic [3:0] REQ_GET     = 4'd4;
	localparam logic [3:0] REQ_SINSERT = 4'd5;
	localparam logic [3:0] REQ_SORT    = 4'd6;
	localparam logic [3:0] REQ_REVERSE = 4'd7;
	localparam logic [3:0] REQ_DEDUP   = 4'd8;

	// Result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BADPOS   = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	// Result beat
	typedef struct packed {
		logic        list_empty;
		logic [7:0]  element_count;
		logic [31:0] read_value;
		logic [7:0]  found_position;
		logic [1:0]  status;
	} result_t;

endpackage

// ===== src/array_list_engine.sv =====
// Clear and rejected requests go straight to the result; retrieve reads one entry; insert,
// delete, locate, sorted insert, dedup and reverse walk the list entry by entry; sort is an
// insertion sort.
// One request in flight at a time; s_tready is low until the result beat is taken.
// Reset clears the element count; the element memory itself is not cleared.
module array_list_engine #(
	parameter int LIST_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // req_type[3:0], position[11:4], value[43:12], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata   // status[1:0], found_position[9:2], read_value[41:10],
	                              // element_count[49:42], list_empty[50], zero fill
);

	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int IW = (CW + 1 > 9) ? CW + 1 : 9;

	// Sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DEC   = 4'd1;
	localparam logic [3:0] S_RD    = 4'd2;  // range check, issue read
	localparam logic [3:0] S_ACT   = 4'd3;  // act on read data
	localparam logic [3:0] S_WR    = 4'd4;  // extra write (insert value, reverse swap, sort)
	localparam logic [3:0] S_DONE  = 4'd5;
	localparam logic [3:0] S_OUT   = 4'd6;

	logic [3:0]    state_q;
	logic [3:0]    kind_q;
	logic [7:0]    pos_q;
	logic [31:0]   val_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] i_q, j_q;    // walk indexes
	logic [31:0]   tmp_q;       // held element
	logic [31:0]   a_q;         // first of a swap pair
	logic          phase_q;
	ale_pkg::result_t res_q;
	logic [1:0]    st_q;
	logic [7:0]    fpos_q;
	logic [31:0]   rval_q;

	// Element memory, one port
	logic [31:0] mem [LIST_DEPTH];
	logic [31:0] rd_q;
	logic [AW-1:0] addr;
	logic          we;
	logic [31:0]   wd;

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wd;
		rd_q <= mem[addr];
	end

	// Shared compare unit
	logic signed [31:0] cmp_a, cmp_b;
	logic cmp_gt, cmp_eq;
	assign cmp_gt = cmp_a > cmp_b;
	assign cmp_eq = cmp_a == cmp_b;

	always_comb begin
		cmp_a = rd_q;
		cmp_b = val_q;
		case (kind_q)
			ale_pkg::REQ_SINSERT: begin
				cmp_a = val_q; cmp_b = rd_q;
			end
			ale_pkg::REQ_SORT, ale_pkg::REQ_DEDUP: cmp_b = tmp_q;
			default: ;
		endcase
	end

	logic [IW-1:0] cnt_x, pos_x;
	assign cnt_x = {{(IW-CW){1'b0}}, count_q};
	assign pos_x = {{(IW-8){1'b0}}, pos_q};

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata  = {5'd0, res_q};

	// Memory control per state
	always_comb begin
		addr = i_q[AW-1:0];
		we = 1'b0;
		wd = rd_q;
		case (state_q)
			S_RD: begin
				case (kind_q)
					ale_pkg::REQ_INSERT, ale_pkg::REQ_SINSERT: begin
						// shift phase reads the source below the destination
						if (phase_q) addr = AW'(i_q - 1'b1);
					end
					ale_pkg::REQ_REVERSE, ale_pkg::REQ_SORT: begin
						if (phase_q) addr = AW'(j_q - 1'b1);
					end
					default: ;
				endcase
			end
			S_ACT: begin
				case (kind_q)
					ale_pkg::REQ_INSERT, ale_pkg::REQ_SINSERT: begin
						if (phase_q) begin
							we = 1'b1; addr = i_q[AW-1:0];
						end
					end
					ale_pkg::REQ_DELETE: begin
						we = 1'b1; addr = AW'(i_q - 1'b1);
					end
					ale_pkg::REQ_REVERSE: begin
						if (phase_q) begin
							we = 1'b1; addr = i_q[AW-1:0];
						end
					end
					ale_pkg::REQ_DEDUP: begin
						if (phase_q && !cmp_eq) begin
							we = 1'b1; addr = AW'(j_q + 1'b1);
						end
					end
					ale_pkg::REQ_SORT: begin
						if (phase_q && cmp_gt) begin
							we = 1'b1; addr = j_q[AW-1:0];
						end
					end
					default: ;
				endcase
			end
			S_WR: begin
				case (kind_q)
					ale_pkg::REQ_INSERT, ale_pkg::REQ_SINSERT: begin
						we = 1'b1; addr = j_q[AW-1:0]; wd = val_q;
					end
					ale_pkg::REQ_REVERSE: begin
						we = 1'b1; addr = AW'(j_q - 1'b1); wd = a_q;
					end
					ale_pkg::REQ_SORT: begin
						we = 1'b1; addr = j_q[AW-1:0]; wd = tmp_q;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= '0;
			pos_q   <= '0;
			val_q   <= '0;
			count_q <= '0;
			i_q     <= '0;
			j_q     <= '0;
			tmp_q   <= '0;
			a_q     <= '0;
			phase_q <= 1'b0;
			res_q   <= '0;
			st_q    <= ale_pkg::ST_OK;
			fpos_q  <= '0;
			rval_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						kind_q  <= s_tdata[3:0];
						pos_q   <= s_tdata[11:4];
						val_q   <= s_tdata[43:12];
						st_q    <= ale_pkg::ST_OK;
						fpos_q  <= '0;
						rval_q  <= '0;
						phase_q <= 1'b0;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					state_q <= S_DONE;
					case (kind_q)
						ale_pkg::REQ_CLEAR: count_q <= '0;
						ale_pkg::REQ_INSERT: begin
							if (pos_x == '0 || pos_x > cnt_x)
								st_q <= ale_pkg::ST_BADPOS;
							else if (cnt_x >= IW'(LIST_DEPTH))
								st_q <= ale_pkg::ST_FULL;
							else begin
								// shift up from count down to pos-1
								i_q <= cnt_x; j_q <= pos_x - 1'b1;
								phase_q <= 1'b1; fpos_q <= pos_q; state_q <= S_RD;
							end
						end
						ale_pkg::REQ_SINSERT: begin
							if (cnt_x >= IW'(LIST_DEPTH))
								st_q <= ale_pkg::ST_FULL;
							else begin
								// scan phase: find first not-less
								i_q <= '0; phase_q <= 1'b0; state_q <= S_RD;
							end
						end
						ale_pkg::REQ_DELETE, ale_pkg::REQ_GET: begin
							if (pos_x == '0 || pos_x > cnt_x)
								st_q <= ale_pkg::ST_BADPOS;
							else begin
								fpos_q <= pos_q;
								i_q <= (kind_q == ale_pkg::REQ_GET) ? pos_x - 1'b1 : pos_x;
								state_q <= S_RD;
							end
						end
						ale_pkg::REQ_LOCATE: begin
							st_q <= ale_pkg::ST_NOTFOUND;
							i_q <= '0; state_q <= S_RD;
						end
						ale_pkg::REQ_SORT: begin
							i_q <= IW'(1); phase_q <= 1'b0; state_q <= S_RD;
						end
						ale_pkg::REQ_REVERSE: begin
							// j_q is one past the upper element of the pair
							i_q <= '0; j_q <= cnt_x; phase_q <= 1'b0;
							state_q <= S_RD;
						end
						ale_pkg::REQ_DEDUP: begin
							if (cnt_x > IW'(1)) begin
								i_q <= '0; j_q <= '0; phase_q <= 1'b0;
								state_q <= S_RD;
							end
						end
						default: st_q <= ale_pkg::ST_BADPOS;
					endcase
				end
				S_RD: begin
					// range checks before each read
					state_q <= S_ACT;
					case (kind_q)
						ale_pkg::REQ_INSERT, ale_pkg::REQ_SINSERT: begin
							if (phase_q) begin
								if (i_q == j_q) state_q <= S_WR;  // gap reached
							end else if (i_q >= cnt_x) begin
								j_q <= i_q; i_q <= cnt_x; phase_q <= 1'b1;
								fpos_q <= 8'(i_q + 1'b1);
								state_q <= S_RD;
							end
						end
						ale_pkg::REQ_DELETE: begin
							if (i_q >= cnt_x) begin
								count_q <= count_q - 1'b1; state_q <= S_DONE;
							end
						end
						ale_pkg::REQ_LOCATE: begin
							if (i_q >= cnt_x) state_q <= S_DONE;
						end
						ale_pkg::REQ_SORT: begin
							if (!phase_q && i_q >= cnt_x) state_q <= S_DONE;
							else if (phase_q && j_q == '0) state_q <= S_WR;
						end
						ale_pkg::REQ_REVERSE: begin
							if (!phase_q && i_q + 1'b1 >= j_q) state_q <= S_DONE;
						end
						ale_pkg::REQ_DEDUP: begin
							if (phase_q && i_q >= cnt_x) begin
								count_q <= CW'(j_q + 1'b1); state_q <= S_DONE;
							end
						end
						default: ;
					endcase
				end
				S_ACT: begin
					state_q <= S_RD;
					case (kind_q)
						ale_pkg::REQ_GET: begin
							rval_q <= rd_q; state_q <= S_DONE;
						end
						ale_pkg::REQ_INSERT, ale_pkg::REQ_SINSERT: begin
							if (phase_q)
								i_q <= i_q - 1'b1;
							else if (cmp_gt)
								i_q <= i_q + 1'b1;  // value above element: keep scanning
							else begin
								j_q <= i_q; i_q <= cnt_x; phase_q <= 1'b1;
								fpos_q <= 8'(i_q + 1'b1);
							end
						end
						ale_pkg::REQ_DELETE: i_q <= i_q + 1'b1;
						ale_pkg::REQ_LOCATE: begin
							if (cmp_eq) begin
								st_q <= ale_pkg::ST_OK;
								fpos_q <= 8'(i_q + 1'b1);
								state_q <= S_DONE;
							end else
								i_q <= i_q + 1'b1;
						end
						ale_pkg::REQ_REVERSE: begin
							// upper element written at i now, lower one next
							if (!phase_q) begin
								a_q <= rd_q; phase_q <= 1'b1;
							end else
								state_q <= S_WR;
						end
						ale_pkg::REQ_DEDUP: begin
							if (!phase_q) begin
								tmp_q <= rd_q; phase_q <= 1'b1; i_q <= IW'(1);
							end else begin
								if (!cmp_eq) begin
									j_q <= j_q + 1'b1; tmp_q <= rd_q;
								end
								i_q <= i_q + 1'b1;
							end
						end
						ale_pkg::REQ_SORT: begin
							if (!phase_q) begin
								tmp_q <= rd_q; j_q <= i_q; phase_q <= 1'b1;
							end else if (cmp_gt)
								j_q <= j_q - 1'b1;
							else
								state_q <= S_WR;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_WR: begin
					state_q <= S_RD;
					case (kind_q)
						ale_pkg::REQ_INSERT, ale_pkg::REQ_SINSERT: begin
							count_q <= count_q + 1'b1; state_q <= S_DONE;
						end
						ale_pkg::REQ_REVERSE: begin
							i_q <= i_q + 1'b1; j_q <= j_q - 1'b1; phase_q <= 1'b0;
						end
						default: begin
							// sort: next outer element
							i_q <= i_q + 1'b1; phase_q <= 1'b0;
						end
					endcase
				end
				S_DONE: begin
					res_q.status         <= st_q;
					res_q.found_position <= fpos_q;
					res_q.read_value     <= rval_q;
					res_q.element_count  <= 8'(count_q);
					res_q.list_empty     <= (count_q == '0);
					state_q <= S_OUT;
				end
				S_OUT: if (m_tready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== bench/array_list_engine_tb.sv =====
`timescale 1ns / 1ps

module array_list_engine_tb;

	localparam int DEPTH = 128;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // req_type[3:0], position[11:4], value[43:12], zero fill
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;   // status[1:0], found_position[9:2], read_value[41:10],
	                        // element_count[49:42], list_empty[50], zero fill

	// Shadow copy of the list
	logic [31:0] shadow_list [DEPTH];
	int          shadow_len;

	ale_pkg::result_t pending_results [$];
	int          mismatch_count;
	bit          tx_idle;
	bit          rx_idle;
	int          rx_hold;

	array_list_engine #(.LIST_DEPTH(DEPTH)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#500_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Applies one request to the shadow list and returns the result it should give
	function automatic ale_pkg::result_t apply_request(logic [3:0] kind, logic [7:0] pos,
	                                                   logic [31:0] val);
		ale_pkg::result_t r;
		int          i;
		int          j;
		logic [31:0] t;
		r = '0;
		r.status = ale_pkg::ST_OK;
		case (kind)
			ale_pkg::REQ_CLEAR: shadow_len = 0;
			ale_pkg::REQ_INSERT: begin
				if (pos < 1 || pos > shadow_len) begin
					r.status = ale_pkg::ST_BADPOS;
				end else if (shadow_len >= DEPTH) begin
					r.status = ale_pkg::ST_FULL;
				end else begin
					for (i = shadow_len; i > pos - 1; i--)
						shadow_list[i] = shadow_list[i - 1];
					shadow_list[pos - 1] = val;
					shadow_len++;
					r.found_position = pos;
				end
			end
			ale_pkg::REQ_DELETE: begin
				if (pos < 1 || pos > shadow_len) begin
					r.status = ale_pkg::ST_BADPOS;
				end else begin
					for (i = pos - 1; i + 1 < shadow_len; i++)
						shadow_list[i] = shadow_list[i + 1];
					shadow_len--;
					r.found_position = pos;
				end
			end
			ale_pkg::REQ_LOCATE: begin
				r.status = ale_pkg::ST_NOTFOUND;
				for (i = 0; i < shadow_len; i++) begin
					if (shadow_list[i] == val) begin
						r.status = ale_pkg::ST_OK;
						r.found_position = 8'(i + 1);
						break;
					end
				end
			end
			ale_pkg::REQ_GET: begin
				if (pos < 1 || pos > shadow_len) begin
					r.status = ale_pkg::ST_BADPOS;
				end else begin
					r.read_value = shadow_list[pos - 1];
					r.found_position = pos;
				end
			end
			ale_pkg::REQ_SINSERT: begin
				if (shadow_len >= DEPTH) begin
					r.status = ale_pkg::ST_FULL;
				end else begin
					j = 0;
					while (j < shadow_len && $signed(val) > $signed(shadow_list[j]))
						j++;
					for (i = shadow_len; i > j; i--)
						shadow_list[i] = shadow_list[i - 1];
					shadow_list[j] = val;
					shadow_len++;
					r.found_position = 8'(j + 1);
				end
			end
			ale_pkg::REQ_SORT: begin
				for (i = 1; i < shadow_len; i++) begin
					t = shadow_list[i];
					j = i;
					while (j > 0 && $signed(shadow_list[j - 1]) > $signed(t)) begin
						shadow_list[j] = shadow_list[j - 1];
						j--;
					end
					shadow_list[j] = t;
				end
			end
			ale_pkg::REQ_REVERSE: begin
				for (i = 0; i < shadow_len / 2; i++) begin
					t = shadow_list[i];
					shadow_list[i] = shadow_list[shadow_len - 1 - i];
					shadow_list[shadow_len - 1 - i] = t;
				end
			end
			ale_pkg::REQ_DEDUP: begin
				if (shadow_len > 1) begin
					j = 0;
					for (i = 1; i < shadow_len; i++) begin
						if (shadow_list[i] != shadow_list[j]) begin
							j++;
							shadow_list[j] = shadow_list[i];
						end
					end
					shadow_len = j + 1;
				end
			end
			default: r.status = ale_pkg::ST_BADPOS;
		endcase
		r.element_count = 8'(shadow_len);
		r.list_empty = (shadow_len == 0);
		return r;
	endfunction

	// Sends one request beat; valid stays up across back-to-back beats
	task automatic send_req(logic [3:0] kind, logic [7:0] pos, logic [31:0] val);
		int gap;
		gap = tx_idle ? $urandom_range(0, 13) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, val, pos, kind};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(apply_request(kind, pos, val));
	endtask

	// Drops valid and waits for every outstanding result
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	// Receiver: random backpressure plus an optional long hold-off
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			int w;
			@(negedge clk);
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				repeat (rx_hold) @(negedge clk);
				rx_hold = 0;
			end
			w = rx_idle ? $urandom_range(0, 13) : 0;
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Result checker
	always @(posedge clk) begin
		ale_pkg::result_t got;
		ale_pkg::result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			got = ale_pkg::result_t'(m_tdata[50:0]);
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result beat %h", m_tdata);
			end else begin
				exp_r = pending_results.pop_front();
				if (got !== exp_r || m_tdata[55:51] !== '0) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("mismatch: exp st=%0d pos=%0d val=%h cnt=%0d emp=%0d",
						         exp_r.status, exp_r.found_position, exp_r.read_value,
						         exp_r.element_count, exp_r.list_empty);
						$display("          got st=%0d pos=%0d val=%h cnt=%0d emp=%0d",
						         got.status, got.found_position, got.read_value,
						         got.element_count, got.list_empty);
					end
				end
			end
		end
	end

	// Edge cases on a small list
	task automatic directed_test();
		send_req(ale_pkg::REQ_GET, 8'd1, 32'h0);
		send_req(ale_pkg::REQ_INSERT, 8'd1, 32'h5);          // insert into empty is rejected
		send_req(ale_pkg::REQ_DELETE, 8'd1, 32'h0);
		send_req(ale_pkg::REQ_LOCATE, 8'd0, 32'h0);
		send_req(ale_pkg::REQ_SORT, 8'd0, 32'h0);
		send_req(ale_pkg::REQ_REVERSE, 8'd0, 32'h0);
		send_req(ale_pkg::REQ_DEDUP, 8'd0, 32'h0);
		send_req(ale_pkg::REQ_SINSERT, 8'd0, 32'h7FFF_FFFF);
		send_req(ale_pkg::REQ_SINSERT, 8'd0, 32'h8000_0000);
		send_req(ale_pkg::REQ_SINSERT, 8'd0, 32'h0);
		send_req(ale_pkg::REQ_INSERT, 8'd1, 32'hFFFF_FFFF);
		send_req(ale_pkg::REQ_INSERT, 8'd4, 32'h0);
		send_req(ale_pkg::REQ_INSERT, 8'd6, 32'h1);          // past the end
		send_req(ale_pkg::REQ_GET, 8'd0, 32'h0);
		send_req(ale_pkg::REQ_GET, 8'd5, 32'h0);
		send_req(ale_pkg::REQ_GET, 8'd255, 32'h0);
		send_req(ale_pkg::REQ_LOCATE, 8'd0, 32'h0);
		send_req(ale_pkg::REQ_LOCATE, 8'd0, 32'h1234_5678);  // miss
		send_req(ale_pkg::REQ_SORT, 8'd0, 32'h0);
		send_req(ale_pkg::REQ_DEDUP, 8'd0, 32'h0);
		send_req(ale_pkg::REQ_REVERSE, 8'd0, 32'h0);
		send_req(ale_pkg::REQ_DELETE, 8'd1, 32'h0);
		send_req(4'd9, 8'd1, 32'h0);                         // unknown kinds
		send_req(4'd15, 8'd128, 32'h0);
		send_req(ale_pkg::REQ_CLEAR, 8'd0, 32'h0);
	endtask

	// Fill to capacity and hit the full cases
	task automatic full_list_test();
		repeat (DEPTH) send_req(ale_pkg::REQ_SINSERT, 8'd0, $urandom_range(0, 40) - 20);
		send_req(ale_pkg::REQ_INSERT, 8'd1, 32'h1);
		send_req(ale_pkg::REQ_SINSERT, 8'd0, 32'h1);
		send_req(ale_pkg::REQ_GET, 8'd128, 32'h0);
		send_req(ale_pkg::REQ_REVERSE, 8'd0, 32'h0);
		send_req(ale_pkg::REQ_SORT, 8'd0, 32'h0);
		send_req(ale_pkg::REQ_DEDUP, 8'd0, 32'h0);
		send_req(ale_pkg::REQ_CLEAR, 8'd0, 32'h0);
	endtask

	// Receiver holds off while requests keep coming, then sender waits for all results
	task automatic backpressure_test();
		wait_drained();
		rx_hold = 400;
		tx_idle = 1'b0;
		repeat (12) send_req(ale_pkg::REQ_SINSERT, 8'd0, $urandom);
		tx_idle = 1'b1;
		wait_drained();
	endtask

	function automatic logic [7:0] pick_pos();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 8'($urandom);
		if (r == 1) return 8'd0;
		if (r == 2) return 8'(shadow_len + 1);
		return 8'($urandom_range(1, shadow_len > 0 ? shadow_len : 1));
	endfunction

	function automatic logic [31:0] pick_val();
		if ($urandom_range(0, 2) == 0) return $urandom;
		if (shadow_len > 0 && $urandom_range(0, 1) == 0)
			return shadow_list[$urandom_range(0, shadow_len - 1)];
		return $urandom_range(0, 16) - 8;
	endfunction

	task automatic random_test(int n);
		int          r;
		logic [3:0]  kind;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 22)      kind = ale_pkg::REQ_SINSERT;
			else if (r < 42) kind = ale_pkg::REQ_INSERT;
			else if (r < 54) kind = ale_pkg::REQ_DELETE;
			else if (r < 66) kind = ale_pkg::REQ_LOCATE;
			else if (r < 78) kind = ale_pkg::REQ_GET;
			else if (r < 83) kind = ale_pkg::REQ_SORT;
			else if (r < 88) kind = ale_pkg::REQ_REVERSE;
			else if (r < 94) kind = ale_pkg::REQ_DEDUP;
			else if (r < 97) kind = ale_pkg::REQ_CLEAR;
			else             kind = 4'($urandom_range(9, 15));
			// stretches without idling on either side
			if (($urandom & 63) == 0) begin
				tx_idle = 1'($urandom_range(0, 1));
				rx_idle = 1'($urandom_range(0, 1));
			end
			send_req(kind, pick_pos(), pick_val());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		shadow_len = 0;
		mismatch_count = 0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		rx_hold = 0;
		for (int i = 0; i < DEPTH; i++) shadow_list[i] = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed_test();
		full_list_test();
		backpressure_test();
		random_test(540);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		wait_drained();
		repeat (50) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
